// ===== hw/rtl/ubxack_pkg.sv =====
// shared types and constants of the frame receiver with acknowledge matching
package ubxack_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;
   localparam logic [7:0] ACK_CLASS   = 8'h05;
   localparam logic [7:0] ACK_ID_ACK  = 8'h01;
   localparam logic [7:0] ACK_ID_NAK  = 8'h00;

   localparam int OUT_LEN_W = 6;
   localparam int OUT_IDX_W = 6;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_EXPECTED_CLASS = 2'd0,
      CSR_EXPECTED_ID    = 2'd1,
      CSR_TIMEOUT_MS     = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OTHER   = 2'd0,
      ST_ACK     = 2'd1,
      ST_NAK     = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN1    = 4'd4,
      PH_LEN2    = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CKA     = 4'd7,
      PH_CKB     = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FETCH = 2'd1,
      BK_LOAD  = 2'd2,
      BK_SHOW  = 2'd3
   } back_state_type;

   // one finished run as handed from the parser to the emitter
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] msg_class;
      logic [7:0] msg_id;
      logic       bank;
   } job_type;

endpackage

// ===== hw/rtl/ubxack_if.sv =====
// channel interfaces: received items, results and register writes
interface ubxack_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_byte;
   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ubxack_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] msg_class;
   logic [7:0] msg_id;
   logic [5:0] payload_len;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic       last;
   modport source (output valid, output status, output msg_class, output msg_id,
                   output payload_len, output byte_index, output payload_byte,
                   output last, input ready);
   modport sink   (input valid, input status, input msg_class, input msg_id,
                   input payload_len, input byte_index, input payload_byte,
                   input last, output ready);
endinterface

interface ubxack_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ubxack_ram.sv =====
// generic single write port ram with registered read
module ubxack_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ubxack_front.sv =====
// frame parser: sync hunt, checksum, ack classification and timeout timer
module ubxack_front #(
   parameter int MAX_PAYLOAD = 40,
   parameter int LEN_W       = 6,
   parameter int ADDR_W      = 7
) (
   input  logic                clock,
   input  logic                reset,
   ubxack_req_if.sink          req_if,
   ubxack_csr_if.sink          csr_if,
   input  logic                fifo_full,
   output logic                push,
   output ubxack_pkg::job_type push_job,
   output logic [LEN_W-1:0]    push_len,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [7:0]          wr_data
);

   ubxack_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  cka_ff, cka_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] taken_ff, taken_in;
   logic [7:0]  p0_ff, p0_in;
   logic [7:0]  p1_ff, p1_in;
   logic        bank_ff, bank_in;
   logic        awaiting_ff, awaiting_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  exp_class_ff;
   logic [7:0]  exp_id_ff;
   logic [15:0] timeout_ff;

   logic        accept;
   logic        is_byte;
   logic [7:0]  b;
   logic [7:0]  base_a;
   logic [7:0]  base_b;
   logic [7:0]  fl_a;
   logic [7:0]  fl_b;
   logic [15:0] full_len;
   logic [LEN_W-1:0] taken_inc;
   logic        check_ok;
   logic        ack_match;
   logic [15:0] elapsed_sat;
   logic        timed_out;

   assign req_if.ready = !fifo_full;
   assign csr_if.ready = 1'b1;
   assign accept   = req_if.valid && req_if.ready;
   assign is_byte  = accept && (req_if.op == ubxack_pkg::OP_BYTE);
   assign b        = req_if.data_byte;

   // class byte restarts both sums
   assign base_a    = (phase_ff == ubxack_pkg::PH_CLASS) ? 8'd0 : sum_a_ff;
   assign base_b    = (phase_ff == ubxack_pkg::PH_CLASS) ? 8'd0 : sum_b_ff;
   assign fl_a      = base_a + b;
   assign fl_b      = base_b + fl_a;
   assign full_len  = {b, len_lo_ff};
   assign taken_inc = taken_ff + LEN_W'(1);
   assign check_ok  = (cka_ff == sum_a_ff) && (b == sum_b_ff);
   assign ack_match = (class_ff == ubxack_pkg::ACK_CLASS) && (len_ff == LEN_W'(2))
                      && (p0_ff == exp_class_ff) && (p1_ff == exp_id_ff);
   assign elapsed_sat = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign timed_out   = accept && (req_if.op == ubxack_pkg::OP_TICK) && awaiting_ff
                        && (elapsed_sat >= timeout_ff);

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (req_if.op)
            ubxack_pkg::OP_BYTE: begin
               case (phase_ff)
                  ubxack_pkg::PH_SYNC1: begin
                     phase_in = (b == ubxack_pkg::SYNC_FIRST) ? ubxack_pkg::PH_SYNC2
                                                              : ubxack_pkg::PH_SYNC1;
                  end
                  ubxack_pkg::PH_SYNC2: begin
                     phase_in = (b == ubxack_pkg::SYNC_SECOND) ? ubxack_pkg::PH_CLASS
                                                               : ubxack_pkg::PH_SYNC1;
                  end
                  ubxack_pkg::PH_CLASS: phase_in = ubxack_pkg::PH_ID;
                  ubxack_pkg::PH_ID:    phase_in = ubxack_pkg::PH_LEN1;
                  ubxack_pkg::PH_LEN1:  phase_in = ubxack_pkg::PH_LEN2;
                  ubxack_pkg::PH_LEN2: begin
                     if (full_len == 16'd0) begin
                        phase_in = ubxack_pkg::PH_CKA;
                     end else if (full_len > 16'(MAX_PAYLOAD)) begin
                        phase_in = ubxack_pkg::PH_SYNC1;
                     end else begin
                        phase_in = ubxack_pkg::PH_PAYLOAD;
                     end
                  end
                  ubxack_pkg::PH_PAYLOAD: begin
                     if (taken_inc >= len_ff) begin
                        phase_in = ubxack_pkg::PH_CKA;
                     end
                  end
                  ubxack_pkg::PH_CKA: phase_in = ubxack_pkg::PH_CKB;
                  default:            phase_in = ubxack_pkg::PH_SYNC1;
               endcase
            end
            ubxack_pkg::OP_TICK: begin
               if (timed_out) begin
                  phase_in = ubxack_pkg::PH_SYNC1;
               end
            end
            ubxack_pkg::OP_START: phase_in = ubxack_pkg::PH_SYNC1;
            default: phase_in = phase_ff;
         endcase
      end
   end

   // datapath and job output
   always_comb begin
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      cka_in      = cka_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      len_lo_in   = len_lo_ff;
      len_in      = len_ff;
      taken_in    = taken_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      bank_in     = bank_ff;
      awaiting_in = awaiting_ff;
      elapsed_in  = elapsed_ff;
      push        = 1'b0;
      push_job    = '0;
      push_len    = len_ff;
      wr_en       = 1'b0;
      if (is_byte) begin
         case (phase_ff)
            ubxack_pkg::PH_CLASS: begin
               class_in = b;
               sum_a_in = fl_a;
               sum_b_in = fl_b;
            end
            ubxack_pkg::PH_ID: begin
               id_in    = b;
               sum_a_in = fl_a;
               sum_b_in = fl_b;
            end
            ubxack_pkg::PH_LEN1: begin
               len_lo_in = b;
               sum_a_in  = fl_a;
               sum_b_in  = fl_b;
            end
            ubxack_pkg::PH_LEN2: begin
               len_in   = LEN_W'(full_len);
               taken_in = '0;
               sum_a_in = fl_a;
               sum_b_in = fl_b;
            end
            ubxack_pkg::PH_PAYLOAD: begin
               wr_en    = 1'b1;
               taken_in = taken_inc;
               sum_a_in = fl_a;
               sum_b_in = fl_b;
               if (taken_ff == LEN_W'(0)) begin
                  p0_in = b;
               end
               if (taken_ff == LEN_W'(1)) begin
                  p1_in = b;
               end
            end
            ubxack_pkg::PH_CKA: cka_in = b;
            ubxack_pkg::PH_CKB: begin
               if (check_ok) begin
                  push               = 1'b1;
                  push_job.msg_class = class_ff;
                  push_job.msg_id    = id_ff;
                  push_job.bank      = bank_ff;
                  push_job.status    = ubxack_pkg::ST_OTHER;
                  if (ack_match && id_ff == ubxack_pkg::ACK_ID_ACK) begin
                     push_job.status = ubxack_pkg::ST_ACK;
                     awaiting_in     = 1'b0;
                  end else if (ack_match && id_ff == ubxack_pkg::ACK_ID_NAK) begin
                     push_job.status = ubxack_pkg::ST_NAK;
                     awaiting_in     = 1'b0;
                  end
                  // a run with payload keeps its bank until emitted
                  if (len_ff != '0) begin
                     bank_in = !bank_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (accept && req_if.op == ubxack_pkg::OP_TICK) begin
         if (awaiting_ff) begin
            elapsed_in = elapsed_sat;
            if (timed_out) begin
               awaiting_in     = 1'b0;
               push            = 1'b1;
               push_job.status = ubxack_pkg::ST_TIMEOUT;
               push_len        = '0;
            end
         end
      end else if (accept && req_if.op == ubxack_pkg::OP_START) begin
         sum_a_in    = 8'd0;
         sum_b_in    = 8'd0;
         taken_in    = '0;
         elapsed_in  = 16'd0;
         awaiting_in = 1'b1;
      end
   end

   assign wr_addr = bank_ff ? (ADDR_W'(taken_ff) + ADDR_W'(MAX_PAYLOAD))
                            : ADDR_W'(taken_ff);
   assign wr_data = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ubxack_pkg::PH_SYNC1;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         taken_ff     <= '0;
         bank_ff      <= 1'b0;
         awaiting_ff  <= 1'b0;
         elapsed_ff   <= 16'd0;
         exp_class_ff <= 8'd0;
         exp_id_ff    <= 8'd0;
         timeout_ff   <= ubxack_pkg::TIMEOUT_RESET;
      end else begin
         phase_ff    <= phase_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         taken_ff    <= taken_in;
         bank_ff     <= bank_in;
         awaiting_ff <= awaiting_in;
         elapsed_ff  <= elapsed_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               ubxack_pkg::CSR_EXPECTED_CLASS: exp_class_ff <= csr_if.data[7:0];
               ubxack_pkg::CSR_EXPECTED_ID:    exp_id_ff    <= csr_if.data[7:0];
               ubxack_pkg::CSR_TIMEOUT_MS:     timeout_ff   <= csr_if.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cka_ff    <= cka_in;
      class_ff  <= class_in;
      id_ff     <= id_in;
      len_lo_ff <= len_lo_in;
      len_ff    <= len_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
   end

endmodule

// ===== hw/rtl/ubxack_fifo.sv =====
// two-entry job queue between parser and emitter
module ubxack_fifo #(
   parameter int DW = 26
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output logic [DW-1:0] head_data
);

   logic [DW-1:0] data_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ubxack_back.sv =====
// result emitter: walks the payload of the queued run out to the result channel
module ubxack_back #(
   parameter int MAX_PAYLOAD = 40,
   parameter int LEN_W       = 6,
   parameter int ADDR_W      = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ubxack_pkg::job_type head_job,
   input  logic [LEN_W-1:0]    head_len,
   output logic                pop,
   output logic                rd_en,
   output logic [ADDR_W-1:0]   rd_addr,
   input  logic [7:0]          rd_data,
   ubxack_rsp_if.source        rsp_if
);

   ubxack_pkg::back_state_type state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] idx_inc;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             load_empty;
   logic             load_byte;
   logic             advance;

   assign idx_inc = idx_ff + LEN_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ubxack_pkg::BK_IDLE: begin
            if (head_valid) begin
               state_in = (head_len == '0) ? ubxack_pkg::BK_SHOW : ubxack_pkg::BK_FETCH;
            end
         end
         ubxack_pkg::BK_FETCH: state_in = ubxack_pkg::BK_LOAD;
         ubxack_pkg::BK_LOAD:  state_in = ubxack_pkg::BK_SHOW;
         ubxack_pkg::BK_SHOW: begin
            if (rsp_if.ready) begin
               state_in = last_ff ? ubxack_pkg::BK_IDLE : ubxack_pkg::BK_FETCH;
            end
         end
         default: state_in = ubxack_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load_empty = 1'b0;
      load_byte  = 1'b0;
      advance    = 1'b0;
      pop        = 1'b0;
      rd_en      = 1'b0;
      case (state_ff)
         ubxack_pkg::BK_IDLE:  load_empty = head_valid && (head_len == '0);
         ubxack_pkg::BK_FETCH: rd_en      = 1'b1;
         ubxack_pkg::BK_LOAD:  load_byte  = 1'b1;
         ubxack_pkg::BK_SHOW: begin
            pop     = rsp_if.ready && last_ff;
            advance = rsp_if.ready && !last_ff;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = head_job.bank ? (ADDR_W'(idx_ff) + ADDR_W'(MAX_PAYLOAD))
                                  : ADDR_W'(idx_ff);

   always_comb begin
      idx_in  = idx_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      if (state_ff == ubxack_pkg::BK_IDLE) begin
         idx_in = '0;
      end
      if (load_empty) begin
         byte_in = 8'd0;
         last_in = 1'b1;
      end
      if (load_byte) begin
         byte_in = rd_data;
         last_in = (idx_inc == head_len);
      end
      if (advance) begin
         idx_in = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ubxack_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid        = (state_ff == ubxack_pkg::BK_SHOW);
   assign rsp_if.status       = head_job.status;
   assign rsp_if.msg_class    = head_job.msg_class;
   assign rsp_if.msg_id       = head_job.msg_id;
   assign rsp_if.payload_len  = ubxack_pkg::OUT_LEN_W'(head_len);
   assign rsp_if.byte_index   = ubxack_pkg::OUT_IDX_W'(idx_ff);
   assign rsp_if.payload_byte = byte_ff;
   assign rsp_if.last         = last_ff;

endmodule

// ===== hw/rtl/ubx_frame_receiver_ack_match_top.sv =====
// Frame receiver with acknowledge matching: received bytes, ms ticks and
// start events in on req_if; one transaction per payload byte out on rsp_if
// (one transaction for an empty frame or a timeout); registers on csr_if,
// index 0 expected class, 1 expected id, 2 timeout in ms.
// The parser takes one req transaction per cycle while its job queue has
// room. A frame's payload is written into one of two banks of a payload ram,
// so the next frame can be parsed while the previous one is still emitted.
// Each result transaction with payload passes through the emitter's ram
// read, registered read data and output register with handshake (states
// fetch, load and show); for an empty frame or a timeout the queue head
// goes straight to the output register, with no ram read.
// When rsp_if is stalled the result is held in its output register; the run
// being emitted and one more finished run fit in the queue, then
// req_if.ready drops.
// Reset is synchronous: parser to sync hunting, no acknowledge awaited,
// timeout 1000 ms, expected class and id zero, queue empty.
// csr_if is always ready; writes are meant for when the block is idle.
module ubx_frame_receiver_ack_match_top #(
   parameter int MAX_PAYLOAD = 40
) (
   input  logic         clock,
   input  logic         reset,
   ubxack_req_if.sink   req_if,
   ubxack_rsp_if.source rsp_if,
   ubxack_csr_if.sink   csr_if
);

   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int DEPTH  = 2 * MAX_PAYLOAD;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int JOB_W  = $bits(ubxack_pkg::job_type);
   localparam int DW     = JOB_W + LEN_W;

   logic                push;
   ubxack_pkg::job_type push_job;
   logic [LEN_W-1:0]    push_len;
   logic                fifo_full;
   logic                pop;
   logic                head_valid;
   logic [DW-1:0]       head_data;
   ubxack_pkg::job_type head_job;
   logic [LEN_W-1:0]    head_len;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [7:0]          rd_data;

   ubxack_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_if    (csr_if),
      .fifo_full (fifo_full),
      .push      (push),
      .push_job  (push_job),
      .push_len  (push_len),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   ubxack_fifo #(
      .DW (DW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_len, push_job}),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_job = head_data[JOB_W-1:0];
   assign head_len = head_data[DW-1:JOB_W];

   ubxack_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ubxack_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_len   (head_len),
      .pop        (pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== verif/tb_top.sv =====
// testbench for the frame receiver: directed and random traffic checked by a scoreboard
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD = 40;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] msg_class;
      logic [7:0] msg_id;
      logic [5:0] payload_len;
      logic [5:0] byte_index;
      logic [7:0] payload_byte;
      logic       last;
   } rsp_item_type;

   // tracks parser, checksum and ack timer state and queues the runs it predicts
   class ack_frame_tracker;
      logic [7:0]            exp_class;
      logic [7:0]            exp_id;
      logic [15:0]           timeout_ms;
      ubxack_pkg::phase_type phase;
      logic [7:0]            sum_a;
      logic [7:0]            sum_b;
      logic [7:0]            rx_check_a;
      logic [7:0]            fr_class;
      logic [7:0]            fr_id;
      logic [15:0]           fr_len;
      int                    taken;
      logic [7:0]            store[MAX_PAYLOAD];
      bit                    awaiting;
      int                    elapsed;
      rsp_item_type          pending_results[$];
      int                    errors;

      function new();
         exp_class  = 8'h00;
         exp_id     = 8'h00;
         timeout_ms = ubxack_pkg::TIMEOUT_RESET;
         phase      = ubxack_pkg::PH_SYNC1;
         sum_a      = 8'h00;
         sum_b      = 8'h00;
         rx_check_a = 8'h00;
         fr_class   = 8'h00;
         fr_id      = 8'h00;
         fr_len     = 16'h0000;
         taken      = 0;
         awaiting   = 1'b0;
         elapsed    = 0;
         errors     = 0;
      endfunction

      function void write_reg(ubxack_pkg::csr_index_type idx, logic [15:0] v);
         case (idx)
            ubxack_pkg::CSR_EXPECTED_CLASS: exp_class = v[7:0];
            ubxack_pkg::CSR_EXPECTED_ID:    exp_id = v[7:0];
            ubxack_pkg::CSR_TIMEOUT_MS:     timeout_ms = v;
            default: ;
         endcase
      endfunction

      function void add_sum(logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      function void push_result(ubxack_pkg::status_type st, logic [7:0] c, logic [7:0] i,
                                logic [5:0] len, logic [5:0] idx, logic [7:0] pb,
                                logic l);
         rsp_item_type r;
         r.status       = st;
         r.msg_class    = c;
         r.msg_id       = i;
         r.payload_len  = len;
         r.byte_index   = idx;
         r.payload_byte = pb;
         r.last         = l;
         pending_results.push_back(r);
      endfunction

      function void emit_run();
         ubxack_pkg::status_type st;
         st = ubxack_pkg::ST_OTHER;
         if (fr_class == ubxack_pkg::ACK_CLASS && fr_len == 16'd2 &&
             store[0] == exp_class && store[1] == exp_id) begin
            if (fr_id == ubxack_pkg::ACK_ID_ACK) st = ubxack_pkg::ST_ACK;
            else if (fr_id == ubxack_pkg::ACK_ID_NAK) st = ubxack_pkg::ST_NAK;
         end
         if (st != ubxack_pkg::ST_OTHER) awaiting = 1'b0;
         if (fr_len == 16'd0) begin
            push_result(st, fr_class, fr_id, 6'd0, 6'd0, 8'h00, 1'b1);
         end else begin
            for (int i = 0; i < fr_len; i++)
               push_result(st, fr_class, fr_id, fr_len[5:0], 6'(i), store[i],
                           i == fr_len - 1);
         end
      endfunction

      function void parse_byte(logic [7:0] b);
         case (phase)
            ubxack_pkg::PH_SYNC1: begin
               if (b == ubxack_pkg::SYNC_FIRST) phase = ubxack_pkg::PH_SYNC2;
            end
            ubxack_pkg::PH_SYNC2: begin
               if (b == ubxack_pkg::SYNC_SECOND) phase = ubxack_pkg::PH_CLASS;
               else phase = ubxack_pkg::PH_SYNC1;
            end
            ubxack_pkg::PH_CLASS: begin
               sum_a = 8'h00;
               sum_b = 8'h00;
               fr_class = b;
               add_sum(b);
               phase = ubxack_pkg::PH_ID;
            end
            ubxack_pkg::PH_ID: begin
               fr_id = b;
               add_sum(b);
               phase = ubxack_pkg::PH_LEN1;
            end
            ubxack_pkg::PH_LEN1: begin
               fr_len = {8'h00, b};
               add_sum(b);
               phase = ubxack_pkg::PH_LEN2;
            end
            ubxack_pkg::PH_LEN2: begin
               fr_len[15:8] = b;
               add_sum(b);
               taken = 0;
               if (fr_len == 16'd0) phase = ubxack_pkg::PH_CKA;
               else if (fr_len > MAX_PAYLOAD) phase = ubxack_pkg::PH_SYNC1;
               else phase = ubxack_pkg::PH_PAYLOAD;
            end
            ubxack_pkg::PH_PAYLOAD: begin
               if (taken < MAX_PAYLOAD) store[taken] = b;
               taken++;
               add_sum(b);
               if (taken >= fr_len) phase = ubxack_pkg::PH_CKA;
            end
            ubxack_pkg::PH_CKA: begin
               rx_check_a = b;
               phase = ubxack_pkg::PH_CKB;
            end
            ubxack_pkg::PH_CKB: begin
               phase = ubxack_pkg::PH_SYNC1;
               if (rx_check_a == sum_a && b == sum_b) emit_run();
            end
            default: phase = ubxack_pkg::PH_SYNC1;
         endcase
      endfunction

      function void take_request(ubxack_pkg::op_type op, logic [7:0] b);
         case (op)
            ubxack_pkg::OP_BYTE: parse_byte(b);
            ubxack_pkg::OP_TICK: begin
               if (awaiting) begin
                  if (elapsed < 65535) elapsed++;
                  if (elapsed >= timeout_ms) begin
                     awaiting = 1'b0;
                     phase = ubxack_pkg::PH_SYNC1;
                     push_result(ubxack_pkg::ST_TIMEOUT, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00,
                                 1'b1);
                  end
               end
            end
            ubxack_pkg::OP_START: begin
               phase = ubxack_pkg::PH_SYNC1;
               sum_a = 8'h00;
               sum_b = 8'h00;
               taken = 0;
               elapsed = 0;
               awaiting = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction

      function void report(string field, logic [15:0] e, logic [15:0] a);
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, e, a);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, got %p", $time, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.msg_class !== want.msg_class)
            report("msg_class", want.msg_class, got.msg_class);
         if (got.msg_id !== want.msg_id) report("msg_id", want.msg_id, got.msg_id);
         if (got.payload_len !== want.payload_len)
            report("payload_len", want.payload_len, got.payload_len);
         if (got.byte_index !== want.byte_index)
            report("byte_index", want.byte_index, got.byte_index);
         if (got.payload_byte !== want.payload_byte)
            report("payload_byte", want.payload_byte, got.payload_byte);
         if (got.last !== want.last) report("last", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;

   ubxack_req_if req_if();
   ubxack_rsp_if rsp_if();
   ubxack_csr_if csr_if();

   ack_frame_tracker tracker = new();

   ubx_frame_receiver_ack_match_top #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= steady || ($urandom_range(99) >= 18);
   end

   // outputs are stable at the falling edge; the transaction completes at the next rise
   always @(negedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = {rsp_if.status, rsp_if.msg_class, rsp_if.msg_id, rsp_if.payload_len,
                rsp_if.byte_index, rsp_if.payload_byte, rsp_if.last};
         tracker.check_response(got);
      end
   end

   task automatic send_item(input ubxack_pkg::op_type op, input logic [7:0] b);
      while (!steady && $urandom_range(99) < 18) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.data_byte <= b;
      do @(negedge clock); while (req_if.ready !== 1'b1);
      @(posedge clock);
      tracker.take_request(op, b);
   endtask

   task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid,
                             input logic [15:0] len, input byte_q_type body,
                             input logic [7:0] flip_a, input logic [7:0] flip_b);
      logic [7:0] ca;
      logic [7:0] cb;
      byte_q_type framed;
      framed = {cls, mid, len[7:0], len[15:8]};
      framed = {framed, body};
      ca = 8'h00;
      cb = 8'h00;
      foreach (framed[k]) begin
         ca = ca + framed[k];
         cb = cb + ca;
      end
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_FIRST);
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_SECOND);
      foreach (framed[k]) send_item(ubxack_pkg::OP_BYTE, framed[k]);
      send_item(ubxack_pkg::OP_BYTE, ca ^ flip_a);
      send_item(ubxack_pkg::OP_BYTE, cb ^ flip_b);
   endtask

   function automatic byte_q_type rand_body(input int n);
      byte_q_type q;
      repeat (n) q.push_back(8'($urandom));
      return q;
   endfunction

   // hold off until every predicted result is out, then let the pipeline settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input ubxack_pkg::csr_index_type idx, input logic [15:0] v);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= v;
      do @(negedge clock); while (csr_if.ready !== 1'b1);
      @(posedge clock);
      tracker.write_reg(idx, v);
   endtask

   task automatic set_config(input logic [7:0] cls, input logic [7:0] mid,
                             input logic [15:0] tmo);
      write_reg(ubxack_pkg::CSR_UNUSED, 16'($urandom));
      write_reg(ubxack_pkg::CSR_EXPECTED_CLASS, {8'($urandom), cls});
      write_reg(ubxack_pkg::CSR_EXPECTED_ID, {8'($urandom), mid});
      write_reg(ubxack_pkg::CSR_TIMEOUT_MS, tmo);
      csr_if.valid <= 1'b0;
   endtask

   task automatic random_event();
      int pick;
      int len;
      logic [7:0] cls;
      logic [7:0] mid;
      logic [7:0] fa;
      logic [7:0] fb;
      byte_q_type body;
      pick = $urandom_range(99);
      if (pick < 50) begin
         if ($urandom_range(99) < 20) begin
            cls = ubxack_pkg::ACK_CLASS;
            case ($urandom_range(2))
               0: mid = ubxack_pkg::ACK_ID_ACK;
               1: mid = ubxack_pkg::ACK_ID_NAK;
               default: mid = 8'($urandom);
            endcase
            len = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 2;
         end else begin
            cls = 8'($urandom);
            mid = 8'($urandom);
            case ($urandom_range(9))
               0, 1: len = $urandom_range(7, 20);
               2:    len = $urandom_range(21, MAX_PAYLOAD);
               default: len = $urandom_range(0, 6);
            endcase
         end
         send_frame(cls, mid, 16'(len), rand_body(len), 8'h00, 8'h00);
      end else if (pick < 60) begin
         // acknowledgement aimed at the awaited command, sometimes slightly off
         mid = ($urandom_range(1) == 1) ? ubxack_pkg::ACK_ID_ACK : ubxack_pkg::ACK_ID_NAK;
         body = {tracker.exp_class, tracker.exp_id};
         if ($urandom_range(4) == 0) body[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
         send_frame(ubxack_pkg::ACK_CLASS, mid, 16'd2, body, 8'h00, 8'h00);
      end else if (pick < 68) begin
         fa = ($urandom_range(1) == 1) ? 8'($urandom) : 8'h00;
         fb = ($urandom_range(1) == 1) ? 8'($urandom) : 8'h00;
         if (fa == 8'h00 && fb == 8'h00) fb = 8'($urandom_range(1, 255));
         len = $urandom_range(0, 8);
         send_frame(8'($urandom), 8'($urandom), 16'(len), rand_body(len), fa, fb);
      end else if (pick < 73) begin
         len = ($urandom_range(1) == 1) ? $urandom_range(MAX_PAYLOAD + 1, 255)
                                        : $urandom_range(256, 65535);
         send_frame(8'($urandom), 8'($urandom), 16'(len), rand_body($urandom_range(4)),
                    8'h00, 8'h00);
      end else if (pick < 80) begin
         // frame cut short; later bytes land in its payload
         len = $urandom_range(1, MAX_PAYLOAD);
         send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_FIRST);
         send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_SECOND);
         send_item(ubxack_pkg::OP_BYTE, 8'($urandom));
         send_item(ubxack_pkg::OP_BYTE, 8'($urandom));
         send_item(ubxack_pkg::OP_BYTE, 8'(len));
         send_item(ubxack_pkg::OP_BYTE, 8'h00);
         repeat ($urandom_range(0, len - 1)) send_item(ubxack_pkg::OP_BYTE, 8'($urandom));
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 8)) send_item(ubxack_pkg::OP_TICK, 8'($urandom));
      end else if (pick < 93) begin
         send_item(ubxack_pkg::OP_START, 8'($urandom));
      end else if (pick < 97) begin
         repeat ($urandom_range(1, 4))
            send_item(ubxack_pkg::OP_BYTE,
                      ($urandom_range(3) == 0) ? ubxack_pkg::SYNC_FIRST : 8'($urandom));
      end else begin
         send_item(ubxack_pkg::OP_NONE, 8'($urandom));
      end
   endtask

   initial begin
      byte_q_type body;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.op <= ubxack_pkg::OP_NONE;
      req_if.data_byte <= 8'h00;
      csr_if.valid <= 1'b0;
      csr_if.index <= ubxack_pkg::CSR_UNUSED;
      csr_if.data <= 16'h0000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, first with the register values from reset
      send_item(ubxack_pkg::OP_NONE, 8'hFF);
      send_item(ubxack_pkg::OP_TICK, 8'h00);
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_FIRST);
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_FIRST);
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_SECOND);
      body.delete();
      send_frame(8'hFF, 8'hFF, 16'd0, body, 8'h00, 8'h00);
      send_frame(8'h0A, 8'h04, 16'd0, body, 8'h01, 8'h00);
      send_frame(8'h0A, 8'h04, 16'd0, body, 8'h00, 8'h80);
      // longest run with neither side idling
      steady = 1'b1;
      body = rand_body(MAX_PAYLOAD);
      body[0] = 8'h00;
      body[MAX_PAYLOAD - 1] = 8'hFF;
      send_frame(8'h00, 8'h00, 16'(MAX_PAYLOAD), body, 8'h00, 8'h00);
      wait_drained();
      steady = 1'b0;
      send_frame(8'h02, 8'h13, 16'(MAX_PAYLOAD + 1), rand_body(1), 8'h00, 8'h00);
      send_item(ubxack_pkg::OP_START, 8'h00);
      body = {8'h00, 8'h00};
      send_frame(ubxack_pkg::ACK_CLASS, ubxack_pkg::ACK_ID_ACK, 16'd2, body, 8'h00, 8'h00);
      send_item(ubxack_pkg::OP_START, 8'hFF);
      send_frame(ubxack_pkg::ACK_CLASS, ubxack_pkg::ACK_ID_NAK, 16'd2, body, 8'h00, 8'h00);
      wait_drained();

      set_config(8'h06, 8'h8A, 16'd3);
      send_item(ubxack_pkg::OP_START, 8'h00);
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_FIRST);
      send_item(ubxack_pkg::OP_BYTE, ubxack_pkg::SYNC_SECOND);
      send_item(ubxack_pkg::OP_BYTE, 8'h06);
      // start in the middle of a frame throws the partial frame away
      send_item(ubxack_pkg::OP_START, 8'h00);
      repeat (4) send_item(ubxack_pkg::OP_TICK, 8'h00);
      send_item(ubxack_pkg::OP_START, 8'h00);
      body = {8'h06, 8'h8A};
      send_frame(ubxack_pkg::ACK_CLASS, ubxack_pkg::ACK_ID_ACK, 16'd2, body, 8'h00, 8'h00);
      repeat (3) send_item(ubxack_pkg::OP_TICK, 8'h00);

      // random part, one register setting per phase
      for (int ph = 0; ph < 3; ph++) begin
         wait_drained();
         case (ph)
            0: set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
            1: set_config(8'hFF, 8'hFF, 16'd0);
            default: set_config(8'h00, 8'h00, 16'($urandom_range(5, 30)));
         endcase
         send_item(ubxack_pkg::OP_START, 8'($urandom));
         random_event();
         send_item(ubxack_pkg::OP_TICK, 8'($urandom));
      end
      wait_drained();

      if (tracker.errors == 0 && tracker.pending_count() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ubxack_pkg.sv
hw/rtl/ubxack_if.sv
hw/rtl/ubxack_ram.sv
hw/rtl/ubxack_front.sv
hw/rtl/ubxack_fifo.sv
hw/rtl/ubxack_back.sv
hw/rtl/ubx_frame_receiver_ack_match_top.sv
verif/tb_top.sv
